[hw/rtl/lad_pkg.sv]
package lad_pkg;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] status_t;
  typedef logic [31:0] word_t;

  // command codes
  localparam cmd_t CMD_PUSH_LEFT  = 2'd0;
  localparam cmd_t CMD_PUSH_RIGHT = 2'd1;
  localparam cmd_t CMD_POP_LEFT   = 2'd2;
  localparam cmd_t CMD_POP_RIGHT  = 2'd3;

  // result status codes
  localparam status_t STATUS_DONE  = 2'd0;
  localparam status_t STATUS_FULL  = 2'd1;
  localparam status_t STATUS_EMPTY = 2'd2;

endpackage

[hw/rtl/lad_mem.sv]
module lad_mem #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  lad_pkg::word_t           wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output lad_pkg::word_t           rdata
);

  lad_pkg::word_t mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/linear_array_deque.sv]
// linear_array_deque: double-ended queue over a non-wrapping array of DEPTH
// signed 32-bit words, held in a synchronous memory with a registered read.
// input channel (in_valid/in_ready) carries cmd and push_value; cmd selects
// push left, push right, pop left or pop right.
// output channel (out_valid/out_ready) returns exactly one item per command:
// pop_value, status (done, full, empty) and the is_empty/is_full flags as
// they stand after the command.
// a push or a refused pop shows its result in the cycle after it is
// accepted; a successful pop first passes through ST_READ for the memory read.
// pushes and refused pops go at one item per cycle while the receiver takes
// results at once; a successful pop holds off the next item while the
// registered read port of the slot memory is read in ST_READ.
// a new item is taken in the same cycle the pending result is taken, so the
// output register parts the two sides; while out_ready is low the result
// holds and in_ready stays low.
// reset clears both indices and the output channel; the slot memory has no
// reset and is only ever read at slots that were written.
module linear_array_deque #(
  parameter int DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  lad_pkg::cmd_t          cmd,
  input  logic signed [31:0]     push_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [31:0]     pop_value,
  output lad_pkg::status_t       status,
  output logic                   is_empty,
  output logic                   is_full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] IDX_DEPTH = IW'(DEPTH);
  localparam logic [IW-1:0] IDX_ONE   = IW'(1);

  // controller states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]    state;
  logic [IW-1:0] front_index;
  logic [IW-1:0] end_index;

  logic [IW-1:0]     front_index_next;
  logic [IW-1:0]     end_index_next;
  lad_pkg::status_t  status_next;
  logic              was_empty;
  logic              accept;

  // memory port signals
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  lad_pkg::word_t    mem_rdata;

  assign in_ready  = (state == ST_IDLE) || ((state == ST_OUT) && out_ready);
  assign out_valid = (state == ST_OUT);
  assign accept    = in_valid && in_ready;
  assign was_empty = front_index >= end_index;

  // index update, memory access and status for the item at the input
  always_comb begin
    front_index_next = front_index;
    end_index_next   = end_index;
    status_next      = lad_pkg::STATUS_DONE;
    mem_we           = 1'b0;
    mem_waddr        = front_index[AW-1:0];
    mem_re           = 1'b0;
    mem_raddr        = front_index[AW-1:0];
    case (cmd)
      lad_pkg::CMD_PUSH_LEFT: begin
        if ((front_index == '0) && (end_index == '0)) begin
          // reset-empty queue: word lands at slot zero
          mem_we         = accept;
          mem_waddr      = '0;
          end_index_next = IDX_ONE;
        end else if (front_index == '0) begin
          status_next = lad_pkg::STATUS_FULL;
        end else begin
          front_index_next = front_index - IDX_ONE;
          mem_we           = accept;
          mem_waddr        = front_index_next[AW-1:0];
        end
      end
      lad_pkg::CMD_PUSH_RIGHT: begin
        if (end_index >= IDX_DEPTH) begin
          status_next = lad_pkg::STATUS_FULL;
        end else begin
          mem_we         = accept;
          mem_waddr      = end_index[AW-1:0];
          end_index_next = end_index + IDX_ONE;
        end
      end
      lad_pkg::CMD_POP_LEFT: begin
        if (was_empty) begin
          status_next = lad_pkg::STATUS_EMPTY;
        end else begin
          mem_re           = accept;
          mem_raddr        = front_index[AW-1:0];
          front_index_next = front_index + IDX_ONE;
        end
      end
      default: begin
        // pop right
        if (was_empty) begin
          status_next = lad_pkg::STATUS_EMPTY;
        end else begin
          end_index_next = end_index - IDX_ONE;
          mem_re         = accept;
          mem_raddr      = end_index_next[AW-1:0];
        end
      end
    endcase
  end

  lad_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (push_value),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // control and result registers; payload fields carry no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      front_index <= '0;
      end_index   <= '0;
    end else begin
      case (state)
        ST_IDLE, ST_OUT: begin
          if (accept) begin
            front_index <= front_index_next;
            end_index   <= end_index_next;
            status      <= status_next;
            pop_value   <= '0;
            is_empty    <= front_index_next >= end_index_next;
            is_full     <= (front_index_next == '0) && (end_index_next == IDX_DEPTH);
            // a successful pop goes through ST_READ for the slot read
            state       <= mem_re ? ST_READ : ST_OUT;
          end else if (state == ST_OUT) begin
            if (out_ready) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_READ: begin
          pop_value <= mem_rdata;
          state     <= ST_OUT;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
  import lad_pkg::*;

  localparam int DEPTH = 16;
  localparam int RANDOM_ITEMS = 400;
  localparam int TAIL_CYCLES = 10;
  localparam int CYCLE_LIMIT = 200000;

  // one command item as queued for the driver
  typedef struct {
    cmd_t  op;
    word_t value;
    bit    drain_first;   // hold this item back until every result is in
  } deque_cmd_t;

  // one result item as the deque should return it
  typedef struct {
    word_t   pop_value;
    status_t status;
    logic    is_empty;
    logic    is_full;
  } deque_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // block inputs, all known from time zero
  logic  in_valid   = 1'b0;
  cmd_t  cmd        = CMD_PUSH_LEFT;
  logic signed [31:0] push_value = '0;
  logic  out_ready  = 1'b0;

  // block outputs
  logic               in_ready;
  logic               out_valid;
  logic signed [31:0] pop_value;
  status_t            status;
  logic               is_empty;
  logic               is_full;

  linear_array_deque #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .push_value(push_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pop_value (pop_value),
    .status    (status),
    .is_empty  (is_empty),
    .is_full   (is_full)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // commands waiting to be driven, results waiting to be seen
  deque_cmd_t   cmd_backlog[$];
  deque_reply_t deque_replies[$];

  // shadow copy of the deque state
  word_t      shadow_slots[DEPTH];
  logic [4:0] shadow_front = '0;
  logic [4:0] shadow_end   = '0;

  int n_items_total = 0;
  int n_accepted    = 0;
  int n_fail        = 0;
  int n_cycles      = 0;

  // what the run reached, for the summary
  int n_pops_done     = 0;
  int n_refused_full  = 0;
  int n_refused_empty = 0;
  int n_full_seen     = 0;
  int n_reset_left    = 0;

  // idle rates: sender 33 / receiver 65, then swapped, then no idling
  function automatic int sender_idle_pct();
    if (n_accepted < n_items_total / 3) return 33;
    else if (n_accepted < (2 * n_items_total) / 3) return 65;
    else return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (n_accepted < n_items_total / 3) return 65;
    else if (n_accepted < (2 * n_items_total) / 3) return 33;
    else return 0;
  endfunction

  // advance the shadow deque by one command and queue the result it should give
  function automatic void step_deque(cmd_t op, word_t w);
    deque_reply_t r;
    logic         was_empty;
    r.pop_value = '0;
    r.status    = STATUS_DONE;
    was_empty   = (shadow_front >= shadow_end);
    case (op)
      CMD_PUSH_LEFT: begin
        if (shadow_front == 0 && shadow_end == 0) begin
          // reset-empty state: the word lands in slot 0
          shadow_slots[0] = w;
          shadow_end = 5'd1;
          n_reset_left++;
        end else if (shadow_front == 0) begin
          // no room on the left, the array never wraps
          r.status = STATUS_FULL;
        end else begin
          shadow_front = shadow_front - 5'd1;
          shadow_slots[shadow_front] = w;
        end
      end
      CMD_PUSH_RIGHT: begin
        if (shadow_end >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          shadow_slots[shadow_end] = w;
          shadow_end = shadow_end + 5'd1;
        end
      end
      CMD_POP_LEFT: begin
        if (was_empty) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.pop_value = shadow_slots[shadow_front];
          shadow_front = shadow_front + 5'd1;
        end
      end
      default: begin
        if (was_empty) begin
          r.status = STATUS_EMPTY;
        end else begin
          shadow_end = shadow_end - 5'd1;
          r.pop_value = shadow_slots[shadow_end];
        end
      end
    endcase
    r.is_empty = (shadow_front >= shadow_end);
    r.is_full  = (shadow_front == 0 && shadow_end == DEPTH);
    if (r.status == STATUS_FULL) n_refused_full++;
    if (r.status == STATUS_EMPTY) n_refused_empty++;
    if (r.status == STATUS_DONE && (op == CMD_POP_LEFT || op == CMD_POP_RIGHT)) n_pops_done++;
    if (r.is_full) n_full_seen++;
    deque_replies.push_back(r);
  endfunction

  // driver: takes items from the backlog, keeps valid and payload steady until accepted
  always @(posedge clk) begin : driver
    deque_cmd_t nxt;
    logic       fire;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) begin
        step_deque(cmd, push_value);
        n_accepted++;
      end
      if (!in_valid || fire) begin
        // a flagged item waits until the deque has answered everything
        if (cmd_backlog.size() != 0
            && !(cmd_backlog[0].drain_first && deque_replies.size() != 0)
            && $urandom_range(99) >= sender_idle_pct()) begin
          nxt = cmd_backlog.pop_front();
          in_valid   <= 1'b1;
          cmd        <= nxt.op;
          push_value <= nxt.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each accepted result with the oldest expected one
  always @(posedge clk) begin : monitor
    deque_reply_t exp_r;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (deque_replies.size() == 0) begin
          $error("result item with nothing expected: pop_value %0d status %0d",
                 pop_value, status);
          n_fail++;
        end else begin
          exp_r = deque_replies.pop_front();
          if (pop_value !== exp_r.pop_value) begin
            $error("pop_value: expected %0d, got %0d", $signed(exp_r.pop_value), pop_value);
            n_fail++;
          end
          if (status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status);
            n_fail++;
          end
          if (is_empty !== exp_r.is_empty) begin
            $error("is_empty: expected %0b, got %0b", exp_r.is_empty, is_empty);
            n_fail++;
          end
          if (is_full !== exp_r.is_full) begin
            $error("is_full: expected %0b, got %0b", exp_r.is_full, is_full);
            n_fail++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= receiver_idle_pct());
    end
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin : watchdog
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("** linear_array_deque: FAILED **");
      $finish;
    end
  end

  task automatic add_cmd(cmd_t op, word_t value, bit drain_first);
    deque_cmd_t c;
    c.op = op;
    c.value = value;
    c.drain_first = drain_first;
    cmd_backlog.push_back(c);
  endtask

  function automatic word_t pick_word();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    int   n_rand;
    int   chunk_len;
    int   push_pct;
    int   push_left_pct;
    int   pop_left_pct;
    bit   is_push;
    bit   go_left;
    cmd_t op;

    // directed: both pops on the reset-empty deque
    add_cmd(CMD_POP_LEFT, 32'h1234_5678, 1'b0);
    add_cmd(CMD_POP_RIGHT, 32'hffff_ffff, 1'b0);
    // left push into the reset-empty state goes to slot 0
    add_cmd(CMD_PUSH_LEFT, 32'h8000_0000, 1'b0);
    // front is at slot 0 now, so a left push is refused
    add_cmd(CMD_PUSH_LEFT, 32'h0000_0005, 1'b0);
    // pop right empties it back to the reset-empty state
    add_cmd(CMD_POP_RIGHT, 32'h0, 1'b0);
    // fill from the right up to DEPTH words
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) add_cmd(CMD_PUSH_RIGHT, 32'h7fff_ffff, 1'b0);
      else if (i == DEPTH - 1) add_cmd(CMD_PUSH_RIGHT, 32'h0000_0000, 1'b0);
      else add_cmd(CMD_PUSH_RIGHT, $urandom, 1'b0);
    end
    // push right when full is refused
    add_cmd(CMD_PUSH_RIGHT, 32'h5555_5555, 1'b0);
    // pop left of a full deque, after a pause with nothing in flight
    add_cmd(CMD_POP_LEFT, 32'h0, 1'b1);
    // left push into the freed front slot, full again
    add_cmd(CMD_PUSH_LEFT, 32'hffff_ffff, 1'b0);
    add_cmd(CMD_POP_LEFT, 32'haaaa_aaaa, 1'b0);

    // random: chunks with their own push/pop and left/right bias, so the deque
    // swings between empty, reset-empty and full and the front index moves off slot 0
    n_rand = 0;
    while (n_rand < RANDOM_ITEMS) begin
      chunk_len = $urandom_range(4, 24);
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      push_left_pct = $urandom_range(0, 100);
      pop_left_pct  = $urandom_range(0, 100);
      for (int k = 0; k < chunk_len; k++) begin
        is_push = ($urandom_range(99) < push_pct);
        go_left = ($urandom_range(99) < (is_push ? push_left_pct : pop_left_pct));
        if (is_push) op = go_left ? CMD_PUSH_LEFT : CMD_PUSH_RIGHT;
        else op = go_left ? CMD_POP_LEFT : CMD_POP_RIGHT;
        // another drained pause partway through the random part
        add_cmd(op, pick_word(), (n_rand == RANDOM_ITEMS / 2));
        n_rand++;
      end
    end
    n_items_total = cmd_backlog.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // all items in, then all results out, then a short tail
    while (n_accepted < n_items_total) @(posedge clk);
    while (deque_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (deque_replies.size() != 0) begin
      $error("%0d result items never arrived", deque_replies.size());
      n_fail++;
    end

    $display("ran %0d commands in %0d cycles: %0d pops done, %0d refused full, %0d refused empty",
             n_accepted, n_cycles, n_pops_done, n_refused_full, n_refused_empty);
    $display("full flag seen %0d times, left push into reset-empty deque %0d times",
             n_full_seen, n_reset_left);
    if (n_fail == 0) $display("** linear_array_deque: PASSED **");
    else $display("** linear_array_deque: FAILED **");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/lad_pkg.sv
hw/rtl/lad_mem.sv
hw/rtl/linear_array_deque.sv
verif/tb.sv
